// File: src/spc_pkg.sv
// Shared constants and types of the skin pixel classifier.
// Depends on nothing; imported by the channel interfaces and the top level.
package spc_pkg;

	localparam int ChanW        = 8;
	localparam int CountOutW    = 24;
	localparam int CountBitsDef = 24;
	localparam int CfgIdxW      = 3;
	localparam int CfgDataW     = 8;
	localparam int QFracW       = 16;
	// Cb and Cr in Q16 always land in [2^15, 2^24), so 24 bits hold them exactly
	localparam int ChromaW      = 24;

	typedef logic [ChanW-1:0]     chan_t;
	typedef logic [CountOutW-1:0] count_out_t;
	typedef logic [ChromaW-1:0]   chroma_t;

	// 128.0 in Q16 and the chroma coefficients, each rounded to Q16
	localparam chroma_t ChromaBase = chroma_t'(128) << QFracW;
	localparam chroma_t CbR = chroma_t'(11058);
	localparam chroma_t CbG = chroma_t'(21710);
	localparam chroma_t CbB = chroma_t'(32768);
	localparam chroma_t CrR = chroma_t'(32768);
	localparam chroma_t CrG = chroma_t'(27439);
	localparam chroma_t CrB = chroma_t'(5329);

	typedef enum logic [CfgIdxW-1:0] {
		REG_RED_MIN    = 3'd0,
		REG_GREEN_MIN  = 3'd1,
		REG_BLUE_MIN   = 3'd2,
		REG_SPREAD_MIN = 3'd3,
		REG_CB_LOW     = 3'd4,
		REG_CB_HIGH    = 3'd5,
		REG_CR_LOW     = 3'd6,
		REG_CR_HIGH    = 3'd7
	} cfg_reg_t;

	localparam chan_t RedMinRst    = chan_t'(95);
	localparam chan_t GreenMinRst  = chan_t'(40);
	localparam chan_t BlueMinRst   = chan_t'(20);
	localparam chan_t SpreadMinRst = chan_t'(15);
	localparam chan_t CbLowRst     = chan_t'(77);
	localparam chan_t CbHighRst    = chan_t'(127);
	localparam chan_t CrLowRst     = chan_t'(133);
	localparam chan_t CrHighRst    = chan_t'(173);

endpackage

// File: src/spc_pixel_if.sv
// Pixel request channel: valid/ready handshake with one RGB pixel.
// Depends on spc_pkg.
interface spc_pixel_if import spc_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t red;
	chan_t green;
	chan_t blue;
	logic  frame_last;

	modport source (output valid, red, green, blue, frame_last, input ready);
	modport sink   (input valid, red, green, blue, frame_last, output ready);
endinterface

// File: src/spc_result_if.sv
// Result request channel: valid/ready handshake with mask bit and counts.
// Depends on spc_pkg.
interface spc_result_if import spc_pkg::*; ();
	logic       valid;
	logic       ready;
	logic       is_skin;
	count_out_t skin_count;
	count_out_t pixel_count;
	logic       frame_done;

	modport source (output valid, is_skin, skin_count, pixel_count, frame_done, input ready);
	modport sink   (input valid, is_skin, skin_count, pixel_count, frame_done, output ready);
endinterface

// File: src/skin_pixel_classifier.sv
// Skin pixel classifier: takes one RGB pixel per request and returns the skin mask
// bit with running skin and pixel counts. The block takes a pixel every clock
// cycle unless a held result stalls it; a result passes an input register, then a
// result register, with the single-pass classify-and-count logic between the two
// registers. Counts saturate at 2^COUNT_BITS-1, the result carries
// their low 24 bits, and both clear after a pixel marked frame_last. Thresholds
// are written through cfg_wr_en/cfg_index/cfg_data; the user must write them while no pixel is in flight, unenforced.
// Depends on spc_pkg, spc_pixel_if and spc_result_if.
module skin_pixel_classifier import spc_pkg::*; #(
	parameter int COUNT_BITS = CountBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	spc_pixel_if.sink           pixel,
	spc_result_if.source        result,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	localparam int ExtW = (COUNT_BITS > CountOutW) ? COUNT_BITS : CountOutW;
	localparam logic [COUNT_BITS-1:0] CountLimit = {COUNT_BITS{1'b1}};

	// threshold registers
	chan_t red_min_q, green_min_q, blue_min_q, spread_min_q;
	chan_t cb_low_q, cb_high_q, cr_low_q, cr_high_q;

	// input stage
	logic  valid_s1;
	chan_t red_s1, green_s1, blue_s1;
	logic  last_s1;

	// result stage
	logic       valid_s2;
	logic       is_skin_s2;
	count_out_t skin_count_s2;
	count_out_t pixel_count_s2;
	logic       frame_done_s2;

	logic [COUNT_BITS-1:0] skin_total_q, pixel_total_q;
	logic [COUNT_BITS-1:0] skin_next, pixel_next;
	logic [ExtW-1:0]       skin_ext, pixel_ext;

	logic    ready_s2, adv_s1;
	chan_t   hi, lo, diff_rg;
	chroma_t cb, cr;
	logic    rgb_ok, spread_ok, order_ok, chroma_ok, skin_c;

	assign ready_s2    = !valid_s2 || result.ready;
	assign adv_s1      = valid_s1 && ready_s2;
	assign pixel.ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_min_q    <= RedMinRst;
			green_min_q  <= GreenMinRst;
			blue_min_q   <= BlueMinRst;
			spread_min_q <= SpreadMinRst;
			cb_low_q     <= CbLowRst;
			cb_high_q    <= CbHighRst;
			cr_low_q     <= CrLowRst;
			cr_high_q    <= CrHighRst;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RED_MIN:    red_min_q    <= cfg_data;
				REG_GREEN_MIN:  green_min_q  <= cfg_data;
				REG_BLUE_MIN:   blue_min_q   <= cfg_data;
				REG_SPREAD_MIN: spread_min_q <= cfg_data;
				REG_CB_LOW:     cb_low_q     <= cfg_data;
				REG_CB_HIGH:    cb_high_q    <= cfg_data;
				REG_CR_LOW:     cr_low_q     <= cfg_data;
				REG_CR_HIGH:    cr_high_q    <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid) begin
			red_s1   <= pixel.red;
			green_s1 <= pixel.green;
			blue_s1  <= pixel.blue;
			last_s1  <= pixel.frame_last;
		end
	end

	// RGB rule
	always_comb begin
		hi = red_s1;
		lo = red_s1;
		if (green_s1 > hi) hi = green_s1;
		if (blue_s1 > hi)  hi = blue_s1;
		if (green_s1 < lo) lo = green_s1;
		if (blue_s1 < lo)  lo = blue_s1;
		diff_rg   = (red_s1 > green_s1) ? red_s1 - green_s1 : green_s1 - red_s1;
		rgb_ok    = (red_s1 > red_min_q) && (green_s1 > green_min_q) && (blue_s1 > blue_min_q);
		spread_ok = ((hi - lo) > spread_min_q) && (diff_rg > spread_min_q);
		order_ok  = (red_s1 > green_s1) && (red_s1 > blue_s1);
	end

	// Chroma rule; the final values never leave [0, 2^24), so modulo-2^24 sums are exact
	always_comb begin
		cb = ChromaBase - chroma_t'(red_s1) * CbR - chroma_t'(green_s1) * CbG
			+ chroma_t'(blue_s1) * CbB;
		cr = ChromaBase + chroma_t'(red_s1) * CrR - chroma_t'(green_s1) * CrG
			- chroma_t'(blue_s1) * CrB;
		chroma_ok = (cb >= {cb_low_q, QFracW'(0)}) && (cb <= {cb_high_q, QFracW'(0)})
			&& (cr >= {cr_low_q, QFracW'(0)}) && (cr <= {cr_high_q, QFracW'(0)});
		skin_c = rgb_ok && spread_ok && order_ok && chroma_ok;
	end

	// saturating counts including the current pixel
	always_comb begin
		pixel_next = (pixel_total_q != CountLimit) ? pixel_total_q + 1'b1 : pixel_total_q;
		skin_next  = (skin_c && skin_total_q != CountLimit) ? skin_total_q + 1'b1
			: skin_total_q;
		pixel_ext  = ExtW'(pixel_next);
		skin_ext   = ExtW'(skin_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skin_total_q  <= '0;
			pixel_total_q <= '0;
		end else if (adv_s1) begin
			// drop the totals after the last pixel of an image
			if (last_s1) begin
				skin_total_q  <= '0;
				pixel_total_q <= '0;
			end else begin
				skin_total_q  <= skin_next;
				pixel_total_q <= pixel_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			is_skin_s2     <= skin_c;
			skin_count_s2  <= skin_ext[CountOutW-1:0];
			pixel_count_s2 <= pixel_ext[CountOutW-1:0];
			frame_done_s2  <= last_s1;
		end
	end

	assign result.valid       = valid_s2;
	assign result.is_skin     = is_skin_s2;
	assign result.skin_count  = skin_count_s2;
	assign result.pixel_count = pixel_count_s2;
	assign result.frame_done  = frame_done_s2;

`ifndef SYNTHESIS
	a_skin_le_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		skin_total_q <= pixel_total_q)
		else $error("skin count exceeds pixel count");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (skin_total_q == '0 && pixel_total_q == '0))
		else $error("counts not cleared after last pixel");

	a_pixel_step: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !last_s1 && pixel_total_q != CountLimit)
		|=> pixel_total_q == $past(pixel_total_q) + 1'b1)
		else $error("pixel count did not advance by one");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result.ready) |-> !adv_s1)
		else $error("pending result overwritten");
`endif

endmodule

// File: sim/tb_skin_pixel_classifier.sv
// Self-checking testbench for skin_pixel_classifier: random and directed pixel requests
// are checked against a mask-and-count predictor under several threshold settings.
// Depends on spc_pkg, spc_pixel_if, spc_result_if and the skin_pixel_classifier RTL.
`timescale 1ns / 100ps

module tb_skin_pixel_classifier;
	import spc_pkg::*;

	localparam int          QOne          = 65536;
	localparam int          CbFromR       = 11058;
	localparam int          CbFromG       = 21710;
	localparam int          CbFromB       = 32768;
	localparam int          CrFromR       = 32768;
	localparam int          CrFromG       = 27439;
	localparam int          CrFromB       = 5329;
	localparam longint      CountLimit    = (64'd1 << CountBitsDef) - 1;
	localparam int          ItemsPerPhase = 130;
	localparam int          NumPhases     = 8;
	localparam int unsigned TimeoutCycles = 400000;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
		logic  frame_last;
	} pixel_t;

	typedef struct packed {
		logic       is_skin;
		count_out_t skin_count;
		count_out_t pixel_count;
		logic       frame_done;
	} skin_result_t;

	class skin_scoreboard;
		chan_t           thr [8];
		longint          skin_total;
		longint          pixel_total;
		skin_result_t    pending [$];
		int unsigned     mismatches;

		function new();
			thr[REG_RED_MIN]    = RedMinRst;
			thr[REG_GREEN_MIN]  = GreenMinRst;
			thr[REG_BLUE_MIN]   = BlueMinRst;
			thr[REG_SPREAD_MIN] = SpreadMinRst;
			thr[REG_CB_LOW]     = CbLowRst;
			thr[REG_CB_HIGH]    = CbHighRst;
			thr[REG_CR_LOW]     = CrLowRst;
			thr[REG_CR_HIGH]    = CrHighRst;
			skin_total  = 0;
			pixel_total = 0;
			mismatches  = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, chan_t v);
			thr[idx] = v;
		endfunction

		function bit classify(pixel_t px);
			int r, g, b, hi, lo, diff_rg, cb, cr;
			r = px.red;
			g = px.green;
			b = px.blue;
			hi = (r > g) ? r : g;
			hi = (b > hi) ? b : hi;
			lo = (r < g) ? r : g;
			lo = (b < lo) ? b : lo;
			diff_rg = (r > g) ? r - g : g - r;
			if (!(r > int'(thr[REG_RED_MIN]) && g > int'(thr[REG_GREEN_MIN]) &&
					b > int'(thr[REG_BLUE_MIN])))
				return 1'b0;
			if (!((hi - lo) > int'(thr[REG_SPREAD_MIN]) &&
					diff_rg > int'(thr[REG_SPREAD_MIN])))
				return 1'b0;
			if (!(r > g && r > b))
				return 1'b0;
			// exact Q16 chroma; bounds scaled up instead of rounding Cb/Cr
			cb = 128 * QOne - CbFromR * r - CbFromG * g + CbFromB * b;
			cr = 128 * QOne + CrFromR * r - CrFromG * g - CrFromB * b;
			return cb >= int'(thr[REG_CB_LOW]) * QOne && cb <= int'(thr[REG_CB_HIGH]) * QOne &&
				cr >= int'(thr[REG_CR_LOW]) * QOne && cr <= int'(thr[REG_CR_HIGH]) * QOne;
		endfunction

		function void note_pixel(pixel_t px);
			skin_result_t want;
			bit skin;
			skin = classify(px);
			if (pixel_total < CountLimit)
				pixel_total++;
			if (skin && skin_total < CountLimit)
				skin_total++;
			want.is_skin     = skin;
			want.skin_count  = count_out_t'(skin_total);
			want.pixel_count = count_out_t'(pixel_total);
			want.frame_done  = px.frame_last;
			pending.push_back(want);
			// clear after the last pixel of the image
			if (px.frame_last) begin
				skin_total  = 0;
				pixel_total = 0;
			end
		endfunction

		function void check_result(skin_result_t got);
			skin_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: skin=%0b skin_count=%0d %s%0d done=%0b",
						got.is_skin, got.skin_count, "pixel_count=", got.pixel_count,
						got.frame_done);
				return;
			end
			want = pending.pop_front();
			if (got.is_skin !== want.is_skin || got.skin_count !== want.skin_count ||
					got.pixel_count !== want.pixel_count || got.frame_done !== want.frame_done) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: exp skin=%0b sc=%0d pc=%0d done=%0b, %s%0b sc=%0d pc=%0d done=%0b",
						want.is_skin, want.skin_count, want.pixel_count, want.frame_done,
						"got skin=", got.is_skin, got.skin_count, got.pixel_count,
						got.frame_done);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	spc_pixel_if  pix ();
	spc_result_if res ();

	skin_pixel_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix),
		.result    (res),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	skin_scoreboard sb = new();
	int unsigned    send_idle_pct;
	int unsigned    recv_stall_pct;
	int unsigned    holdoff_left;
	int unsigned    cycle_count;
	int unsigned    frame_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == TimeoutCycles) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// long receiver hold-off, counted down on its own
	always @(posedge clk) begin
		if (holdoff_left != 0)
			holdoff_left <= holdoff_left - 1;
	end

	initial begin
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			res.ready <= (holdoff_left == 0) && ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (arst_n && res.valid && res.ready)
				sb.check_result('{res.is_skin, res.skin_count, res.pixel_count, res.frame_done});
		end
	end

	function automatic pixel_t px_of(int r, int g, int b, bit last);
		pixel_t px;
		px.red        = chan_t'(r);
		px.green      = chan_t'(g);
		px.blue       = chan_t'(b);
		px.frame_last = last;
		return px;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int r, g;
		if (frame_left == 0)
			frame_left = ($urandom_range(9) == 0) ? $urandom_range(300, 60)
				: $urandom_range(40, 1);
		if ($urandom_range(9) < 6) begin
			// skin-like: red on top, green and blue trailing
			r = $urandom_range(255, 90);
			g = $urandom_range(r - 1, 30);
			px.red   = chan_t'(r);
			px.green = chan_t'(g);
			px.blue  = chan_t'($urandom_range(g, 10));
		end else begin
			px.red   = chan_t'($urandom);
			px.green = chan_t'($urandom);
			px.blue  = chan_t'($urandom);
		end
		px.frame_last = (frame_left == 1);
		frame_left--;
		return px;
	endfunction

	task automatic send_pixel(pixel_t px);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			pix.valid <= 1'b0;
		end
		@(negedge clk);
		pix.valid      <= 1'b1;
		pix.red        <= px.red;
		pix.green      <= px.green;
		pix.blue       <= px.blue;
		pix.frame_last <= px.frame_last;
		do
			@(posedge clk);
		while (!pix.ready);
		sb.note_pixel(px);
	endtask

	task automatic write_reg(cfg_reg_t idx, chan_t v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int lo;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		pix.valid      = 1'b0;
		pix.red        = '0;
		pix.green      = '0;
		pix.blue       = '0;
		pix.frame_last = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		holdoff_left   = 0;
		cycle_count    = 0;
		frame_left     = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NumPhases; p++) begin
			case (p)
				1: begin
					// everything open: only nonzero green and blue, spread and red dominance decide
					write_reg(REG_RED_MIN, 8'd0);
					write_reg(REG_GREEN_MIN, 8'd0);
					write_reg(REG_BLUE_MIN, 8'd0);
					write_reg(REG_SPREAD_MIN, 8'd0);
					write_reg(REG_CB_LOW, 8'd0);
					write_reg(REG_CB_HIGH, 8'd255);
					write_reg(REG_CR_LOW, 8'd0);
					write_reg(REG_CR_HIGH, 8'd255);
				end
				2: begin
					write_reg(REG_RED_MIN, 8'd255);
					write_reg(REG_GREEN_MIN, 8'd255);
					write_reg(REG_BLUE_MIN, 8'd255);
					write_reg(REG_SPREAD_MIN, 8'd255);
					write_reg(REG_CB_LOW, 8'd255);
					write_reg(REG_CB_HIGH, 8'd255);
					write_reg(REG_CR_LOW, 8'd255);
					write_reg(REG_CR_HIGH, 8'd255);
				end
				3: begin
					// defaults except an empty Cb window
					write_reg(REG_RED_MIN, RedMinRst);
					write_reg(REG_GREEN_MIN, GreenMinRst);
					write_reg(REG_BLUE_MIN, BlueMinRst);
					write_reg(REG_SPREAD_MIN, SpreadMinRst);
					write_reg(REG_CB_LOW, 8'd200);
					write_reg(REG_CB_HIGH, 8'd50);
					write_reg(REG_CR_LOW, CrLowRst);
					write_reg(REG_CR_HIGH, CrHighRst);
				end
				4, 6: begin
					write_reg(REG_RED_MIN, chan_t'($urandom_range(150)));
					write_reg(REG_GREEN_MIN, chan_t'($urandom_range(100)));
					write_reg(REG_BLUE_MIN, chan_t'($urandom_range(80)));
					write_reg(REG_SPREAD_MIN, chan_t'($urandom_range(40)));
					lo = $urandom_range(110, 50);
					write_reg(REG_CB_LOW, chan_t'(lo));
					write_reg(REG_CB_HIGH, chan_t'($urandom_range(255, lo)));
					lo = $urandom_range(160, 110);
					write_reg(REG_CR_LOW, chan_t'(lo));
					write_reg(REG_CR_HIGH, chan_t'($urandom_range(255, lo)));
				end
				5: begin
					write_reg(REG_CB_LOW, CbLowRst);
					write_reg(REG_CB_HIGH, CbHighRst);
					write_reg(REG_CR_LOW, CrLowRst);
					write_reg(REG_CR_HIGH, CrHighRst);
					write_reg(REG_RED_MIN, RedMinRst);
					write_reg(REG_GREEN_MIN, GreenMinRst);
					write_reg(REG_BLUE_MIN, BlueMinRst);
					write_reg(REG_SPREAD_MIN, SpreadMinRst);
				end
				7: begin
					// narrow chroma windows
					write_reg(REG_CB_LOW, 8'd95);
					write_reg(REG_CB_HIGH, 8'd110);
					write_reg(REG_CR_LOW, 8'd145);
					write_reg(REG_CR_HIGH, 8'd160);
				end
				default: ;
			endcase
			@(negedge clk);
			cfg_wr_en <= 1'b0;

			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase

			if (p == 0) begin
				send_pixel(px_of(200, 120, 90, 0));   // clear skin
				send_pixel(px_of(0, 0, 0, 0));
				send_pixel(px_of(255, 255, 255, 0));
				send_pixel(px_of(255, 0, 0, 0));
				send_pixel(px_of(95, 50, 30, 0));     // red at its minimum
				send_pixel(px_of(96, 50, 30, 0));
				send_pixel(px_of(150, 40, 30, 0));    // green at its minimum
				send_pixel(px_of(150, 60, 20, 0));    // blue at its minimum
				send_pixel(px_of(150, 140, 130, 0));  // red-green gap too small
				send_pixel(px_of(150, 135, 25, 0));   // red-green gap at the limit
				send_pixel(px_of(150, 160, 60, 0));   // green above red
				send_pixel(px_of(150, 100, 150, 0));  // red ties blue
				send_pixel(px_of(255, 254, 0, 0));
				send_pixel(px_of(0, 255, 255, 0));
				send_pixel(px_of(200, 100, 199, 0));  // strong blue pushes Cb out
				send_pixel(px_of(230, 60, 30, 0));    // Cr above its window
				send_pixel(px_of(200, 120, 90, 1));   // end of image
				send_pixel(px_of(200, 120, 90, 1));   // image of one pixel
				send_pixel(px_of(120, 80, 60, 0));
				send_pixel(px_of(255, 128, 1, 1));
			end
			if (p == 4) begin
				@(negedge clk);
				holdoff_left <= 400;
			end
			repeat (ItemsPerPhase) send_pixel(random_pixel());
			@(negedge clk);
			pix.valid <= 1'b0;
			drain();
		end

		repeat (10) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: filelist.f
src/spc_pkg.sv
src/spc_pixel_if.sv
src/spc_result_if.sv
src/skin_pixel_classifier.sv
sim/tb_skin_pixel_classifier.sv
